### rtl/r250_pkg.sv
// ----------------------------------------------------------------------------
// R250 generator package
// Shared constants, codes, types and the diagonal seed conditioning function.
// ----------------------------------------------------------------------------
package r250_pkg;

   // Generator geometry.
   localparam int WORD_BITS  = 15;
   localparam int TABLE_LEN  = 250;
   localparam int LAG_BACK   = 147;
   localparam int LAG_FWD    = 103;
   localparam int DIAG_START = 14;
   localparam int DIAG_STEP  = 11;
   localparam int MAX_TRIES  = 1024;

   // Derived widths.
   localparam int INDEX_W = 8;
   localparam int TRY_W   = $clog2(MAX_TRIES);
   localparam int RANGE_W = WORD_BITS + 1;
   localparam int SEED_W  = 15;
   localparam int BOUND_W = 16;
   localparam int VALUE_W = 15;
   localparam int EXT_W   = (RANGE_W > BOUND_W) ? RANGE_W : BOUND_W;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [RANGE_W-1:0]   range_type;
   typedef logic [INDEX_W-1:0]   index_type;

   // Item action codes.
   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_RAW     = 2'd1,
      ACT_BOUNDED = 2'd2
   } action_type;

   // Dividend selection of the remainder unit.
   typedef enum logic {
      DIV_SPAN = 1'b0,
      DIV_WORD = 1'b1
   } div_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        latch;
      logic        load_write;
      logic        read_pos;
      logic        read_partner;
      logic        draw_write;
      logic        div_start;
      div_sel_type div_sel;
      logic        limit_load;
      logic        result_from_div;
      logic        out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic reject;
      logic retry_ok;
   } status_type;

   // Diagonal conditioning: entry 14+11k keeps the bits below bit
   // WORD_BITS-1-k and gets that bit set.
   function automatic word_type r250_condition(index_type index, word_type word);
      word_type result;
      word_type top;
      int       b;
      result = word;
      for (int k = 0; k < WORD_BITS; k++) begin
         b   = WORD_BITS - 1 - k;
         top = word_type'(1) << b;
         if ((DIAG_START + DIAG_STEP * k < TABLE_LEN) &&
             (index == INDEX_W'(DIAG_START + DIAG_STEP * k))) begin
            result = (word & (top - word_type'(1))) | top;
         end
      end
      return result;
   endfunction

endpackage

### rtl/r250_divider.sv
// ----------------------------------------------------------------------------
// R250 remainder unit
// Restoring division, one dividend bit per cycle, that returns the remainder.
// ----------------------------------------------------------------------------
module r250_divider
   import r250_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  range_type dividend,
   input  range_type divisor,
   output logic      busy,
   output logic      done,
   output range_type remainder
);

   localparam int CNT_W = $clog2(RANGE_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   range_type        quot_ff, quot_in;
   range_type        rem_ff, rem_in;
   range_type        div_ff, div_in;
   logic [RANGE_W:0] shifted;
   logic [RANGE_W:0] diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      shifted  = {rem_ff, quot_ff[RANGE_W-1]};
      diff     = shifted - {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(RANGE_W);
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = quot_ff << 1;
         count_in = count_ff - CNT_W'(1);
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[RANGE_W-1:0];
         end else begin
            rem_in = shifted[RANGE_W-1:0];
         end
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Operand and remainder registers.
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/r250_datapath.sv
// ----------------------------------------------------------------------------
// R250 datapath
// Lag table memory, position, draw registers, limit and the output register.
// ----------------------------------------------------------------------------
module r250_datapath
   import r250_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  index_type          seed_index,
   input  logic [SEED_W-1:0]  seed_value,
   input  logic [BOUND_W-1:0] bound,
   output status_type         status,
   output logic [VALUE_W-1:0] rsp_value
);

   word_type             lag_table [TABLE_LEN];
   index_type            pos_ff, pos_in;
   word_type             rd_ff;
   word_type             a_ff;
   word_type             result_ff, result_in;
   word_type             limit_ff, limit_in;
   range_type            range_ff, range_in;
   logic [TRY_W-1:0]     tries_ff, tries_in;
   logic [VALUE_W-1:0]   out_ff, out_in;

   index_type            partner;
   index_type            rd_addr;
   index_type            wr_addr;
   word_type             wr_data;
   logic                 wr_en;
   logic                 index_ok;
   logic [EXT_W-1:0]     seed_ext;
   logic [EXT_W-1:0]     bound_ext;
   logic [EXT_W-1:0]     span_ext;
   logic [EXT_W-1:0]     out_ext;
   word_type             seed_word;
   word_type             cond_word;
   word_type             draw_word;
   range_type            dividend;
   range_type            remainder;
   logic                 div_busy;
   logic                 div_done;

   // Seed conditioning and range selection.
   always_comb begin
      seed_ext  = EXT_W'(seed_value);
      seed_word = seed_ext[WORD_BITS-1:0];
      cond_word = r250_condition(seed_index, seed_word);
      index_ok  = seed_index < INDEX_W'(TABLE_LEN);
      bound_ext = EXT_W'(bound);
      span_ext  = EXT_W'(1) << WORD_BITS;
      if ((bound_ext == '0) || (bound_ext > span_ext)) begin
         range_in = span_ext[RANGE_W-1:0];
      end else begin
         range_in = bound_ext[RANGE_W-1:0];
      end
   end

   // Table addressing and the new draw word.
   always_comb begin
      if (pos_ff >= INDEX_W'(LAG_BACK)) begin
         partner = pos_ff - INDEX_W'(LAG_BACK);
      end else begin
         partner = pos_ff + INDEX_W'(LAG_FWD);
      end
      rd_addr   = cmd.read_partner ? partner : pos_ff;
      draw_word = a_ff ^ rd_ff;
      wr_en     = (cmd.load_write && index_ok) || cmd.draw_write;
      wr_addr   = cmd.draw_write ? pos_ff : seed_index;
      wr_data   = cmd.draw_write ? draw_word : cond_word;
   end

   // Next values of the datapath registers.
   always_comb begin
      pos_in    = pos_ff;
      tries_in  = tries_ff;
      result_in = result_ff;
      limit_in  = limit_ff;
      out_ext   = EXT_W'(result_ff);
      out_in    = out_ff;
      if (cmd.load_write && index_ok) begin
         pos_in = '0;
      end else if (cmd.draw_write) begin
         if (pos_ff == INDEX_W'(TABLE_LEN - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + INDEX_W'(1);
         end
      end
      if (cmd.latch) begin
         tries_in = '0;
      end else if (cmd.draw_write) begin
         tries_in = tries_ff + TRY_W'(1);
      end
      if (cmd.draw_write) begin
         result_in = draw_word;
      end else if (cmd.result_from_div) begin
         result_in = remainder[WORD_BITS-1:0];
      end
      if (cmd.limit_load) begin
         limit_in = word_type'('1) - remainder[WORD_BITS-1:0];
      end
      if (cmd.out_load) begin
         out_in = out_ext[VALUE_W-1:0];
      end
   end

   // Position register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Lag table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lag_table[wr_addr] <= wr_data;
      end
      if (cmd.read_pos || cmd.read_partner) begin
         rd_ff <= lag_table[rd_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.read_partner) begin
         a_ff <= rd_ff;
      end
      if (cmd.latch) begin
         range_ff <= range_in;
      end
      tries_ff  <= tries_in;
      result_ff <= result_in;
      limit_ff  <= limit_in;
      out_ff    <= out_in;
   end

   // Remainder unit, shared by the limit and the final reduction.
   assign dividend = (cmd.div_sel == DIV_SPAN) ? span_ext[RANGE_W-1:0] : {1'b0, result_ff};

   r250_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (range_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (remainder)
   );

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign status.reject   = draw_word > limit_ff;
   assign status.retry_ok = tries_ff != TRY_W'(MAX_TRIES - 1);
   assign rsp_value       = out_ff;

endmodule

### rtl/r250_controller.sv
// ----------------------------------------------------------------------------
// R250 controller
// Sequences loads, raw draws, rejection retries and the bounded reduction.
// ----------------------------------------------------------------------------
module r250_controller
   import r250_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_action,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RANGE_GO,
      ST_RANGE_WAIT,
      ST_READ_POS,
      ST_READ_PARTNER,
      ST_WRITE,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      bounded_ff, bounded_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;

   // Next state and commands.
   always_comb begin
      cmd           = '0;
      cmd.div_sel   = DIV_SPAN;
      state_in      = state_ff;
      bounded_in    = bounded_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               case (action_type'(req_action))
                  ACT_LOAD: begin
                     cmd.load_write = 1'b1;
                  end
                  ACT_RAW: begin
                     bounded_in = 1'b0;
                     state_in   = ST_READ_POS;
                  end
                  ACT_BOUNDED: begin
                     bounded_in = 1'b1;
                     state_in   = ST_RANGE_GO;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RANGE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SPAN;
            state_in      = ST_RANGE_WAIT;
         end
         ST_RANGE_WAIT: begin
            if (status.div_done) begin
               cmd.limit_load = 1'b1;
               state_in       = ST_READ_POS;
            end
         end
         ST_READ_POS: begin
            cmd.read_pos = 1'b1;
            state_in     = ST_READ_PARTNER;
         end
         ST_READ_PARTNER: begin
            cmd.read_partner = 1'b1;
            state_in         = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.draw_write = 1'b1;
            if (!bounded_ff) begin
               state_in = ST_OUT;
            end else if (status.reject && status.retry_ok) begin
               state_in = ST_READ_POS;
            end else begin
               state_in = ST_MOD_GO;
            end
         end
         ST_MOD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_WORD;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.result_from_div = 1'b1;
               state_in            = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hand the result over once the output register is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bounded_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bounded_ff    <= bounded_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

### rtl/r250_random_generator_core.sv
// ----------------------------------------------------------------------------
// R250 random generator core
// Lagged-Fibonacci XOR generator with seed loading and bounded draws.
// ----------------------------------------------------------------------------
// A load transfer gives no result. A raw draw reads and rewrites the
// 250-word table, which has a single read port: the word at the position
// and its partner 103 entries on are read one after the other, and the new
// word is written back at the position. A bounded draw first forms the
// rejection limit and finally reduces the word, each with the shared
// remainder unit that retires one bit per cycle, and draws a new word for
// each rejected one. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken in.
module r250_random_generator_core
   import r250_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: action[1:0], seed_index[9:2], seed_value[24:10],
   // bound[40:25], zero fill[47:41].
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: value[14:0], zero fill[15].
   output logic [15:0] rsp_tdata
);

   cmd_type            cmd;
   status_type         status;
   logic [VALUE_W-1:0] rsp_value;

   // Sequencing.
   r250_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tdata[1:0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Table, arithmetic and output register.
   r250_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .seed_index (req_tdata[9:2]),
      .seed_value (req_tdata[24:10]),
      .bound      (req_tdata[40:25]),
      .status     (status),
      .rsp_value  (rsp_value)
   );

   assign rsp_tdata = {1'b0, rsp_value};

   // The remainder unit is idle whenever a new item may be taken.
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.div_busy)
      else $error("remainder unit busy while taking a new item");

   // The remainder unit is never restarted while it is working.
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("remainder unit started while busy");

   // A result appears only after the controller loaded the output register.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result shown without an output load");

endmodule
